/* rtl/polynomial_interpolation_eval_top_macros.svh */
// Assertion macros shared by the interpolation block
`ifndef POLYNOMIAL_INTERPOLATION_EVAL_TOP_MACROS_SVH
`define POLYNOMIAL_INTERPOLATION_EVAL_TOP_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle
`define PIE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle
`define PIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/pie_pkg.sv */
package pie_pkg;

    localparam int MaxPoints = 16;
    localparam int FracBits  = 16;
    localparam int DataW     = 32;
    localparam int CountW    = 5;
    localparam int StatusW   = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [StatusW-1:0] ST_OK  = 2'd0;
    localparam logic [StatusW-1:0] ST_DIV = 2'd1;
    localparam logic [StatusW-1:0] ST_SAT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COPY,
        S_DD_RD,
        S_DD_WAIT,
        S_DD_DIV,
        S_DD_WR,
        S_H_INIT,
        S_H_RD,
        S_H_WAIT,
        S_H_MUL,
        S_H_ADD,
        S_DONE
    } pie_state_t;

    // Divider request and response bundle
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } pie_div_ctl_t;

endpackage

/* rtl/pie_ram.sv */
module pie_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // Write one word, read one word registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/pie_div.sv */
module pie_div
    import pie_pkg::*;
#(
    parameter int FracBits = pie_pkg::FracBits
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [DataW:0]         num_in,
    input  logic signed [DataW:0]         den_in,
    output logic signed [DataW+FracBits:0] quo,
    output pie_div_ctl_t                  ctl
);

    localparam int NW = DataW + FracBits + 1;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]      n_reg, n_next;
    logic [DataW:0]     d_reg, d_next;
    logic [DataW+1:0]   r_reg, r_next;
    logic               neg_reg, neg_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [NW-1:0]      num_abs;
    logic [DataW:0]     den_abs;
    logic [DataW+1:0]   trial;
    logic [DataW+1:0]   rsh;
    logic signed [NW-1:0] num_ext;

    assign num_ext = {num_in, {FracBits{1'b0}}};
    assign num_abs = num_ext[NW-1] ? NW'(-num_ext) : num_ext;
    assign den_abs = den_in[DataW] ? (DataW+1)'(-den_in) : den_in;
    assign rsh     = {r_reg[DataW:0], n_reg[NW-1]};
    assign trial   = rsh - {1'b0, d_reg};

    // Step one quotient bit a cycle while busy
    always_comb
    begin
        n_next    = n_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            n_next    = num_abs;
            d_next    = den_abs;
            r_next    = '0;
            neg_next  = num_ext[NW-1] ^ den_in[DataW];
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
        end
        else if (busy_reg)
        begin
            if (!trial[DataW+1])
            begin
                r_next = trial;
                n_next = {n_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = rsh;
                n_next = {n_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
        neg_reg <= neg_next;
    end

    assign quo       = neg_reg ? -$signed(n_reg) : $signed(n_reg);
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;

endmodule

/* rtl/polynomial_interpolation_eval_top.sv */
// Load words give no result.
// Evaluate words compute their divided differences with the bit-serial divider,
// which is shared over every divided difference.
// One word is in flight at a time; the next is taken once the result word is accepted.
// Reset clears control and sets point_count to 1; point stores are undefined until loaded.
module polynomial_interpolation_eval_top
    import pie_pkg::*;
#(
    parameter int MAX_POINTS = pie_pkg::MaxPoints,
    parameter int FRAC_BITS  = pie_pkg::FracBits
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     cmd,
    input  logic [3:0]               point_index,
    input  logic signed [DataW-1:0]  point_x,
    input  logic signed [DataW-1:0]  point_y,
    input  logic signed [DataW-1:0]  query_x,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DataW-1:0]  value,
    output logic [StatusW-1:0]       status,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CountW-1:0]        cfg_data
);

`include "polynomial_interpolation_eval_top_macros.svh"

    localparam int AW = $clog2(MAX_POINTS);
    localparam int QW = DataW + FRAC_BITS + 1;
    localparam int PW = 2 * DataW + 1;
    localparam logic signed [QW-1:0] SatHi = QW'(64'sh7FFFFFFF);
    localparam logic signed [QW-1:0] SatLo = -QW'(64'sh80000000);

    pie_state_t state_reg, state_next;
    logic [CountW-1:0] count_reg;
    logic [AW:0]       n_reg, n_next;
    logic [AW:0]       lvl_reg, lvl_next;
    logic [AW:0]       j_reg, j_next;
    logic              sat_reg, sat_next;
    logic signed [DataW-1:0] q_reg, q_next;
    logic signed [DataW-1:0] p_reg, p_next;
    logic signed [PW-1:0]    prod_reg, prod_next;
    logic signed [DataW-1:0] val_reg, val_next;
    logic [StatusW-1:0]      st_reg, st_next;
    logic                    ov_reg, ov_next;
    logic [AW:0]             ncl;

    // Memory ports: x/y point store and difference store
    logic          x_we, y_we, d_we, ld_ok;
    logic [AW-1:0] x_wa, y_wa, d_wa, x_ra, y_ra, d_ra, d_ra2, d_rb;
    logic [DataW-1:0] x_wd, y_wd, d_wd, x_rd, x_rd2, y_rd, d_rd, d_rd2;

    // Divider
    logic div_go;
    logic signed [DataW:0] div_num, div_den;
    logic signed [QW-1:0]  div_q;
    pie_div_ctl_t div_ctl;

    logic in_acc;
    assign in_acc = in_valid && !in_stall;
    assign ld_ok  = (32'(point_index) < 32'(MAX_POINTS));

    pie_ram #(.Width(DataW), .Depth(MAX_POINTS)) u_xa (
        .clk(clk), .we(x_we), .waddr(x_wa), .wdata(x_wd), .raddr(x_ra), .rdata(x_rd));
    pie_ram #(.Width(DataW), .Depth(MAX_POINTS)) u_xb (
        .clk(clk), .we(x_we), .waddr(x_wa), .wdata(x_wd), .raddr(d_ra2), .rdata(x_rd2));
    pie_ram #(.Width(DataW), .Depth(MAX_POINTS)) u_y (
        .clk(clk), .we(y_we), .waddr(y_wa), .wdata(y_wd), .raddr(y_ra), .rdata(y_rd));
    pie_ram #(.Width(DataW), .Depth(MAX_POINTS)) u_da (
        .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
    pie_ram #(.Width(DataW), .Depth(MAX_POINTS)) u_db (
        .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_rb), .rdata(d_rd2));

    pie_div #(.FracBits(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_go), .num_in(div_num), .den_in(div_den),
        .quo(div_q), .ctl(div_ctl));

    // Clamp point count to 1..MAX_POINTS
    always_comb
    begin
        if (count_reg == '0)
        begin
            ncl = (AW+1)'(1);
        end
        else if (32'(count_reg) > 32'(MAX_POINTS))
        begin
            ncl = (AW+1)'(MAX_POINTS);
        end
        else
        begin
            ncl = (AW+1)'(count_reg);
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign value     = val_reg;
    assign status    = st_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_acc && cmd == CMD_EVAL) state_next = S_COPY;
            S_COPY:    if (j_reg == n_reg) state_next = (n_reg > (AW+1)'(1)) ? S_DD_RD : S_H_INIT;
            S_DD_RD:   state_next = S_DD_WAIT;
            S_DD_WAIT: state_next = (x_rd == x_rd2) ? S_DONE : S_DD_DIV;
            S_DD_DIV:  if (div_ctl.done) state_next = S_DD_WR;
            S_DD_WR:
            begin
                if (j_reg > lvl_reg) state_next = S_DD_RD;
                else if (lvl_reg + 1'b1 < n_reg) state_next = S_DD_RD;
                else state_next = S_H_INIT;
            end
            S_H_INIT:  state_next = S_H_WAIT;
            S_H_RD:    state_next = S_H_WAIT;
            S_H_WAIT:
            begin
                if (j_reg == (AW+1)'(MAX_POINTS))
                    state_next = (n_reg == (AW+1)'(1)) ? S_DONE : S_H_RD;
                else
                    state_next = S_H_MUL;
            end
            S_H_MUL:   state_next = S_H_ADD;
            S_H_ADD:   state_next = (j_reg == '0) ? S_DONE : S_H_RD;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        logic signed [QW-1:0] sq;
        logic signed [PW:0]   acc;
        n_next   = n_reg;
        lvl_next = lvl_reg;
        j_next   = j_reg;
        sat_next = sat_reg;
        q_next   = q_reg;
        p_next   = p_reg;
        prod_next = prod_reg;
        val_next = val_reg;
        st_next  = st_reg;
        ov_next  = ov_reg && out_stall;
        x_we = 1'b0; y_we = 1'b0; d_we = 1'b0;
        x_wa = point_index[AW-1:0]; y_wa = point_index[AW-1:0];
        x_wd = point_x; y_wd = point_y;
        d_wa = j_reg[AW-1:0]; d_wd = y_rd;
        x_ra = j_reg[AW-1:0]; y_ra = j_reg[AW-1:0];
        d_ra = j_reg[AW-1:0]; d_ra2 = AW'(j_reg - lvl_reg);
        d_rb = AW'(j_reg - 1'b1);
        div_go  = 1'b0;
        div_num = $signed({d_rd[DataW-1], d_rd}) - $signed({d_rd2[DataW-1], d_rd2});
        div_den = $signed({x_rd[DataW-1], x_rd}) - $signed({x_rd2[DataW-1], x_rd2});
        sq  = div_q;
        acc = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (cmd == CMD_LOAD)
                    begin
                        x_we = ld_ok;
                        y_we = ld_ok;
                    end
                    else
                    begin
                        n_next = ncl;
                        q_next = query_x;
                        j_next = '0;
                        sat_next = 1'b0;
                    end
                end
            end
            S_COPY:
            begin
                // Copy ordinates into the difference store, one read ahead
                y_ra = j_reg[AW-1:0];
                d_wa = AW'(j_reg - 1'b1);
                d_we = (j_reg != '0);
                j_next = j_reg + 1'b1;
                if (j_reg == n_reg)
                begin
                    lvl_next = (AW+1)'(1);
                    j_next   = n_reg - 1'b1;
                end
            end
            S_DD_RD:
            begin
                // x[j], x[j-l] and d[j], d[j-1]
                x_ra  = j_reg[AW-1:0];
                d_ra  = j_reg[AW-1:0];
                d_ra2 = AW'(j_reg - lvl_reg);
            end
            S_DD_WAIT:
            begin
                d_ra  = j_reg[AW-1:0];
                d_ra2 = AW'(j_reg - lvl_reg);
                div_go = (x_rd != x_rd2);
            end
            S_DD_DIV:
            begin
                d_ra2 = AW'(j_reg - lvl_reg);
            end
            S_DD_WR:
            begin
                if (sq > SatHi) begin sq = SatHi; sat_next = 1'b1; end
                if (sq < SatLo) begin sq = SatLo; sat_next = 1'b1; end
                d_we = 1'b1;
                d_wa = j_reg[AW-1:0];
                d_wd = sq[DataW-1:0];
                if (j_reg > lvl_reg)
                begin
                    j_next = j_reg - 1'b1;
                end
                else
                begin
                    lvl_next = lvl_reg + 1'b1;
                    j_next   = n_reg - 1'b1;
                end
            end
            S_H_INIT:
            begin
                // Fetch the top coefficient
                d_ra = AW'(n_reg - 1'b1);
                j_next = (AW+1)'(MAX_POINTS);
            end
            S_H_RD:
            begin
                d_ra = j_reg[AW-1:0];
                x_ra = j_reg[AW-1:0];
            end
            S_H_WAIT:
            begin
                if (j_reg == (AW+1)'(MAX_POINTS))
                begin
                    p_next = d_rd;
                    j_next = n_reg - 2'd2;
                end
                else
                begin
                    prod_next = PW'(p_reg * ($signed({q_reg[DataW-1], q_reg})
                                - $signed({x_rd[DataW-1], x_rd})));
                end
            end
            S_H_MUL:
            begin
                d_ra = j_reg[AW-1:0];
            end
            S_H_ADD:
            begin
                // Truncating shift toward zero, then add and clamp
                if (prod_reg < 0)
                    acc = (PW+1)'(-((-prod_reg) >>> FRAC_BITS));
                else
                    acc = (PW+1)'(prod_reg >>> FRAC_BITS);
                acc = acc + (PW+1)'($signed(d_rd));
                if (acc > (PW+1)'(64'sh7FFFFFFF))
                begin
                    acc = (PW+1)'(64'sh7FFFFFFF); sat_next = 1'b1;
                end
                if (acc < -(PW+1)'(64'sh80000000))
                begin
                    acc = -(PW+1)'(64'sh80000000); sat_next = 1'b1;
                end
                p_next = acc[DataW-1:0];
                j_next = j_reg - 1'b1;
            end
            S_DONE:
            begin
                ov_next = 1'b1;
                val_next = p_reg;
                st_next  = sat_reg ? ST_SAT : ST_OK;
            end
            default: ;
        endcase
        // A zero denominator ends evaluation with status 1
        if (state_reg == S_DD_WAIT && x_rd == x_rd2)
        begin
            p_next   = '0;
            sat_next = 1'b0;
            val_next = '0;
        end
    end

    // Track the division-by-zero flag separately
    logic dz_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CountW'(1);
            ov_reg    <= 1'b0;
            dz_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            if (state_reg == S_IDLE)
                dz_reg <= 1'b0;
            else if (state_reg == S_DD_WAIT && x_rd == x_rd2)
                dz_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        lvl_reg  <= lvl_next;
        j_reg    <= j_next;
        sat_reg  <= sat_next;
        q_reg    <= q_next;
        p_reg    <= p_next;
        prod_reg <= prod_next;
        val_reg  <= (state_reg == S_DONE && dz_reg) ? '0 : val_next;
        st_reg   <= (state_reg == S_DONE && dz_reg) ? ST_DIV : st_next;
    end

    `PIE_ASSERT_IMP(a_stall_busy, clk, rst_n, state_reg != S_IDLE, in_stall)
    `PIE_ASSERT_NEXT(a_done_out, clk, rst_n, state_reg == S_DONE, out_valid)
    `PIE_ASSERT_IMP(a_div_idle, clk, rst_n, div_ctl.busy, state_reg == S_DD_DIV)
    `PIE_ASSERT_IMP(a_dz_status, clk, rst_n, out_valid && status == ST_DIV, value == '0)

endmodule

/* tb/polynomial_interpolation_eval_checker.sv */
module polynomial_interpolation_eval_checker
    import pie_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic                     cmd,
    input  logic [3:0]               point_index,
    input  logic signed [DataW-1:0]  point_x,
    input  logic signed [DataW-1:0]  point_y,
    input  logic signed [DataW-1:0]  query_x,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [DataW-1:0]  value,
    input  logic [StatusW-1:0]       status,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CountW-1:0]        cfg_data,
    output int                       failures,
    output int                       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [DataW-1:0] value;
        logic [StatusW-1:0]      status;
    } interp_word_t;

    longint          knot_x [MaxPoints];
    longint          knot_y [MaxPoints];
    logic [CountW-1:0] count_reg;
    interp_word_t    pending_values [$];

    // Clamp to the signed 32-bit range and flag any clamp
    function automatic longint clamp32(input longint v, inout bit clamped);
        if (v > 64'sd2147483647) begin
            clamped = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clamped = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Newton divided differences, then Horner evaluation at qx
    function automatic interp_word_t interpolate(input logic signed [DataW-1:0] qx);
        longint       d [MaxPoints];
        longint       p;
        longint       den;
        longint       q;
        bit           clamped;
        int           n;
        interp_word_t r;
        clamped = 1'b0;
        n = int'(count_reg);
        if (n < 1) n = 1;
        if (n > MaxPoints) n = MaxPoints;
        q = longint'(qx);
        for (int j = 0; j < n; j++) d[j] = knot_y[j];
        for (int l = 1; l < n; l++) begin
            for (int j = n - 1; j >= l; j--) begin
                den = knot_x[j] - knot_x[j-l];
                if (den == 0) begin
                    r.value  = '0;
                    r.status = ST_DIV;
                    return r;
                end
                d[j] = clamp32(((d[j] - d[j-1]) * (64'sd1 <<< FracBits)) / den, clamped);
            end
        end
        p = d[n-1];
        for (int i = n - 2; i >= 0; i--)
            p = clamp32(d[i] + (p * (q - knot_x[i])) / (64'sd1 <<< FracBits), clamped);
        r.value  = p[DataW-1:0];
        r.status = clamped ? ST_SAT : ST_OK;
        return r;
    endfunction

    // Track the point store and count, queue predictions, compare result words
    always @(posedge clk or negedge rst_n) begin
        interp_word_t exp_word;
        if (!rst_n) begin
            count_reg   <= 5'd1;
            failures    <= 0;
            outstanding <= 0;
            pending_values.delete();
            for (int i = 0; i < MaxPoints; i++) begin
                knot_x[i] = 0;
                knot_y[i] = 0;
            end
        end else begin
            if (cfg_valid && cfg_ready)
                count_reg <= cfg_data;
            if (in_valid && !in_stall) begin
                if (cmd == CMD_LOAD) begin
                    knot_x[point_index] = longint'(point_x);
                    knot_y[point_index] = longint'(point_y);
                end else begin
                    pending_values.insert(pending_values.size(), interpolate(query_x));
                end
            end
            if (out_valid && !out_stall) begin
                if (pending_values.size() == 0) begin
                    $error("unexpected result word: value %0d status %0d", value, status);
                    failures <= failures + 1;
                end else begin
                    exp_word = pending_values.pop_front();
                    if (value !== exp_word.value || status !== exp_word.status) begin
                        if (value !== exp_word.value)
                            $error("value: expected %0d, actual %0d", exp_word.value, value);
                        if (status !== exp_word.status)
                            $error("status: expected %0d, actual %0d",
                                   exp_word.status, status);
                        failures <= failures + 1;
                    end
                end
            end
            outstanding <= pending_values.size();
        end
    end

endmodule

/* tb/polynomial_interpolation_eval_top_tb.sv */
module polynomial_interpolation_eval_top_tb;
    import pie_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     cmd = CMD_LOAD;
    logic [3:0]               point_index = '0;
    logic signed [DataW-1:0]  point_x = '0;
    logic signed [DataW-1:0]  point_y = '0;
    logic signed [DataW-1:0]  query_x = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DataW-1:0]  value;
    logic [StatusW-1:0]       status;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CountW-1:0]        cfg_data = '0;
    int                       failures;
    int                       outstanding;
    bit                       calm = 1'b0;
    bit                       hold_long = 1'b0;

    polynomial_interpolation_eval_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .point_index(point_index),
        .point_x(point_x), .point_y(point_y), .query_x(query_x),
        .out_valid(out_valid), .out_stall(out_stall),
        .value(value), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    polynomial_interpolation_eval_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .point_index(point_index),
        .point_x(point_x), .point_y(point_y), .query_x(query_x),
        .out_valid(out_valid), .out_stall(out_stall),
        .value(value), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .failures(failures), .outstanding(outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("polynomial_interpolation_eval_top_tb: errors");
        $finish;
    end

    // Draw a Q16.16 value: mostly small, sometimes full range
    function automatic logic signed [DataW-1:0] rand_fix();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return (int'($urandom_range(0, 40)) - 20) * 65536 + int'($urandom_range(0, 65535));
    endfunction

    // Offer one word and hold it until accepted
    task automatic send_word(input logic c, input logic [3:0] idx,
                             input logic signed [DataW-1:0] px,
                             input logic signed [DataW-1:0] py,
                             input logic signed [DataW-1:0] qx);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        point_index <= idx;
        point_x     <= px;
        point_y     <= py;
        query_x     <= qx;
        do @(posedge clk); while (in_stall);
    endtask

    // Drain, let the last load settle, then write the point count
    task automatic write_count(input logic [CountW-1:0] n);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_point(input logic [3:0] idx, input logic signed [DataW-1:0] px,
                              input logic signed [DataW-1:0] py);
        send_word(CMD_LOAD, idx, px, py, rand_fix());
    endtask

    task automatic eval_at(input logic signed [DataW-1:0] qx);
        send_word(CMD_EVAL, 4'($urandom), rand_fix(), rand_fix(), qx);
    endtask

    // Result side: random stall before each word, long hold-off on request
    initial
    begin
        int k;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            k = calm ? 0 : $urandom_range(0, 18);
            if (hold_long)
            begin
                k = 600;
                hold_long = 1'b0;
            end
            if (k > 0)
            begin
                out_stall <= 1'b1;
                repeat (k) @(posedge clk);
                out_stall <= 1'b0;
            end
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin
        logic [CountW-1:0] n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every slot with evenly spaced abscissas
        for (int i = 0; i < MaxPoints; i++)
            load_point(i[3:0], (i - 8) * 65536, int'($urandom_range(0, 200000)) - 100000);
        eval_at(32'sh0003_8000);
        write_count(5'd0);
        eval_at(32'sh8000_0000);
        write_count(5'd2);
        eval_at(32'sh7fff_ffff);
        write_count(5'd3);
        eval_at(32'sh0000_4000);
        // Equal abscissas
        load_point(4'd1, -8 * 65536, 32'sd1000);
        eval_at(32'sd0);
        // Steep slope that clamps
        load_point(4'd1, -8 * 65536 + 1, 32'sh7fff_ffff);
        load_point(4'd0, -8 * 65536, 32'sh8000_0000);
        eval_at(32'sh4000_0000);
        load_point(4'd2, 32'sh7fff_ffff, 32'sh7fff_ffff);
        eval_at(32'sh8000_0000);
        load_point(4'd0, -8 * 65536, 32'sd0);
        load_point(4'd1, -7 * 65536, 32'sd65536);
        load_point(4'd2, -6 * 65536, 32'sd0);
        write_count(5'd16);
        eval_at(32'sd0);
        write_count(5'd31);
        eval_at(32'sd65536);

        // Random phases, mostly few points
        for (int ph = 0; ph < 12; ph++)
        begin
            case ($urandom_range(0, 9))
                0:       n = CountW'($urandom_range(17, 31));
                1:       n = 5'd0;
                2:       n = 5'd1;
                default: n = CountW'($urandom_range(2, 6));
            endcase
            write_count(n);
            calm = (ph % 4 == 3);
            if (ph == 5)
                hold_long = 1'b1;
            for (int it = 0; it < 10; it++)
            begin
                if (ph == 7 && it == 5)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (outstanding != 0) @(posedge clk);
                end
                if ($urandom_range(0, 9) < 6)
                    eval_at(rand_fix());
                else if ($urandom_range(0, 5) == 0)
                    load_point(4'($urandom), (int'($urandom_range(0, 15)) - 8) * 65536,
                               rand_fix());
                else
                    load_point(4'($urandom), rand_fix(), rand_fix());
            end
            calm = 1'b0;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("polynomial_interpolation_eval_top_tb: clean");
        else
            $display("polynomial_interpolation_eval_top_tb: errors");
        $finish;
    end

endmodule
